// ===== design/skipped_key_bounded_store_unit_defines.svh =====
//------------------------------------------------------------------------------
// skipped_key_bounded_store_unit_defines
// Assertion macros used by the store design file.
//------------------------------------------------------------------------------
`ifndef SKIPPED_KEY_BOUNDED_STORE_UNIT_DEFINES_SVH
`define SKIPPED_KEY_BOUNDED_STORE_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside of reset.
`define SKS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after its antecedent.
`define SKS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/sks_pkg.sv =====
//------------------------------------------------------------------------------
// sks_pkg
// Types and constants shared by the skipped key store.
//------------------------------------------------------------------------------
`default_nettype none
package sks_pkg;

    localparam int DefMaxEntries = 32;
    localparam int FillW         = 6;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_FIND = 2'd1,
        OP_DEL  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] epoch;
        logic [31:0] msg_index;
        logic [63:0] key_handle;
    } sks_in_t;

    typedef struct packed {
        logic        found;
        logic [63:0] found_handle;
        logic        status;
        logic        evicted;
        logic [5:0]  fill_count;
    } sks_out_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_MOVE = 2'd2,
        ST_DONE = 2'd3
    } st_t;

    // Entry as stored in memory.
    typedef struct packed {
        logic [31:0] epoch;
        logic [31:0] msg_index;
        logic [63:0] handle;
    } entry_t;

endpackage
`default_nettype wire

// ===== design/skipped_key_bounded_store_unit.sv =====
//------------------------------------------------------------------------------
// skipped_key_bounded_store_unit
// Age-ordered store of skipped message keys with add, find and delete.
//------------------------------------------------------------------------------
// Usage: each beat accepted on s_ (opcode, epoch, msg_index, key_handle)
// gives exactly one beat on m_ (found, found_handle, status, evicted,
// fill_count), in order. Entries sit in a circular buffer in one memory with
// a registered read. An add is a pointer move plus one write; its result
// passes through the done state into the output register. A find reads the
// held entries from newest to oldest, one a cycle, and stops at the first
// hit or after the oldest. A delete walks to the match and then moves each
// older entry one place up, one a cycle; a miss walks all entries like a
// find miss. One item is worked at a time and s_ready is high only while
// the sequencer is idle, so a new item is taken only after the last result
// has left the sequencer. A finished result waits in the output register
// while m_ready is low; the next item is taken and worked meanwhile, but its
// result holds the sequencer until the register is free. Reset empties the
// store at once (the count and head pointer clear); memory contents are not
// cleared and no clearing pass is needed.
//------------------------------------------------------------------------------
`default_nettype none
`include "skipped_key_bounded_store_unit_defines.svh"
module skipped_key_bounded_store_unit
    import sks_pkg::*;
#(
    parameter int MaxEntries = DefMaxEntries
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sks_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sks_out_t      m_data
);

    localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CW = $clog2(MaxEntries + 1);
    localparam logic [CW-1:0] MaxC = CW'(MaxEntries);

    st_t           st_reg, st_next;
    sks_in_t       item_reg;
    logic [AW-1:0] head_reg;     // physical slot of newest entry
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;      // logical position being read
    logic          rd_pend_reg;  // read issued last cycle
    logic [CW-1:0] rd_idx_reg;   // logical index of pending read
    logic [CW-1:0] gap_reg;      // logical slot to fill next
    logic          found_reg;
    logic [63:0]   fhandle_reg;
    logic          status_reg;
    logic          evicted_reg;
    sks_out_t      out_reg;
    logic          mvalid_reg;
    logic          load_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    // Logical position to physical slot: head + pos, wrapped.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                           input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = {1'b0, CW'(h)} + {1'b0, pos};
        if (s >= (CW+1)'(MaxEntries)) begin
            s = s - (CW+1)'(MaxEntries);
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0] new_head;
    assign new_head = (head_reg == '0) ? AW'(MaxEntries - 1) : head_reg - 1'b1;

    sks_mem #(.Depth(MaxEntries)) u_mem (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic hit_find, hit_del;
    assign hit_find = rd_pend_reg && (rdata.epoch == item_reg.epoch)
                      && (rdata.msg_index == item_reg.msg_index);
    assign hit_del  = rd_pend_reg && (rdata.handle == item_reg.key_handle);

    // A finished result moves to the output register once it is free.
    assign load_out = (st_reg == ST_DONE) && (!mvalid_reg || m_ready);

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    // Next state.
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    st_next = (s_data.opcode inside {OP_FIND, OP_DEL}) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (item_reg.opcode == OP_FIND) begin
                    if (hit_find || (!rd_pend_reg && idx_reg >= count_reg)) begin
                        st_next = ST_DONE;
                    end
                end else begin
                    if (hit_del) begin
                        st_next = ST_MOVE;
                    end else if (!rd_pend_reg && idx_reg >= count_reg) begin
                        st_next = ST_DONE;
                    end
                end
            end
            ST_MOVE: begin
                if (!rd_pend_reg && idx_reg >= count_reg) begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE: st_next = load_out ? ST_IDLE : ST_DONE;
            default: st_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        we    = 1'b0;
        waddr = phys(head_reg, gap_reg);
        wdata = rdata;
        raddr = phys(head_reg, idx_reg);
        if (st_reg == ST_IDLE && s_valid && s_ready && s_data.opcode == OP_ADD) begin
            we    = 1'b1;
            waddr = new_head;
            wdata = '{epoch: s_data.epoch, msg_index: s_data.msg_index,
                      handle: s_data.key_handle};
        end else if (st_reg == ST_MOVE && rd_pend_reg) begin
            we    = 1'b1;
            waddr = phys(head_reg, gap_reg);
        end
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
            gap_reg     <= '0;
        end else begin
            st_reg <= st_next;
            // Output register: load a finished result, or clear once taken.
            if (load_out) begin
                mvalid_reg <= 1'b1;
                out_reg    <= '{found: found_reg, found_handle: fhandle_reg,
                                status: status_reg, evicted: evicted_reg,
                                fill_count: FillW'(count_reg)};
            end else if (m_valid && m_ready) begin
                mvalid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    rd_pend_reg <= 1'b0;
                    idx_reg     <= '0;
                    if (s_valid && s_ready) begin
                        item_reg    <= s_data;
                        found_reg   <= 1'b0;
                        fhandle_reg <= '0;
                        status_reg  <= 1'b0;
                        evicted_reg <= (s_data.opcode == OP_ADD) && (count_reg >= MaxC);
                        if (s_data.opcode == OP_ADD) begin
                            head_reg <= new_head;
                            if (count_reg < MaxC) begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (item_reg.opcode == OP_FIND && hit_find) begin
                        found_reg   <= 1'b1;
                        fhandle_reg <= rdata.handle;
                        rd_pend_reg <= 1'b0;
                    end else if (item_reg.opcode == OP_DEL && hit_del) begin
                        // Gap at the match; read the next older entry.
                        gap_reg     <= rd_idx_reg;
                        idx_reg     <= rd_idx_reg + 1'b1;
                        rd_pend_reg <= 1'b0;
                    end else if (idx_reg < count_reg) begin
                        rd_pend_reg <= 1'b1;
                        rd_idx_reg  <= idx_reg;
                        idx_reg     <= idx_reg + 1'b1;
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg && item_reg.opcode == OP_DEL) begin
                            status_reg <= 1'b1;
                        end
                    end
                end
                ST_MOVE: begin
                    if (rd_pend_reg) begin
                        gap_reg <= gap_reg + 1'b1;
                    end
                    if (idx_reg < count_reg) begin
                        rd_pend_reg <= 1'b1;
                        idx_reg     <= idx_reg + 1'b1;
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg) begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `SKS_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= MaxC)
    `SKS_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, st_reg != ST_IDLE, !s_ready)
    `SKS_ASSERT_NEXT(a_done_valid, aclk, aresetn, st_reg == ST_DONE, m_valid)
    `SKS_ASSERT_IMP(a_move_del, aclk, aresetn, st_reg == ST_MOVE, item_reg.opcode == OP_DEL)
    `SKS_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule
`default_nettype wire

// ===== design/sks_mem.sv =====
//------------------------------------------------------------------------------
// sks_mem
// Entry memory: one write port, one read port, registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module sks_mem
    import sks_pkg::*;
#(
    parameter int Depth = DefMaxEntries,
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [Depth];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== dv/sks_checker.sv =====
//------------------------------------------------------------------------------
// sks_checker
// Watches both channels of the skipped key store, keeps its own copy of the
// age-ordered chain, predicts one result per accepted input beat and
// compares every result beat field by field with the oldest prediction.
//------------------------------------------------------------------------------
`default_nettype none
module sks_checker
    import sks_pkg::*;
#(
    parameter int MaxEntries = DefMaxEntries
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  wire sks_in_t  s_data,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  wire sks_out_t m_data,
    output int            err_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the chain: cell 0 is newest.
    entry_t   chain[MaxEntries];
    int       held;
    sks_out_t result_q[$];

    assign pending = result_q.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Applies one operation to the mirror and returns the result it gives.
    function automatic sks_out_t store_apply(input sks_in_t op);
        sks_out_t r;
        int       hit;
        r   = '0;
        hit = -1;
        case (op_t'(op.opcode))
            OP_ADD: begin
                if (held >= MaxEntries) r.evicted = 1'b1;
                else held++;
                for (int i = MaxEntries - 1; i > 0; i--) chain[i] = chain[i-1];
                chain[0] = '{op.epoch, op.msg_index, op.key_handle};
            end
            OP_FIND: begin
                for (int i = 0; i < held; i++) begin
                    if (hit < 0 && chain[i].epoch == op.epoch &&
                        chain[i].msg_index == op.msg_index) hit = i;
                end
                if (hit >= 0) begin
                    r.found        = 1'b1;
                    r.found_handle = chain[hit].handle;
                end
            end
            OP_DEL: begin
                for (int i = 0; i < held; i++) begin
                    if (hit < 0 && chain[i].handle == op.key_handle) hit = i;
                end
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < held; i++) chain[i] = chain[i+1];
                    held--;
                end else begin
                    r.status = 1'b1;
                end
            end
            default: ;
        endcase
        r.fill_count = held[5:0];
        return r;
    endfunction

    // Predict on input beats, compare on result beats.
    always @(posedge aclk) begin
        sks_out_t want;
        if (!aresetn) begin
            held = 0;
            result_q.delete();
            err_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected beat", '0, '0);
                end else begin
                    want = result_q.pop_front();
                    if (m_data.found !== want.found)
                        report_mismatch("found", m_data.found, want.found);
                    if (m_data.found_handle !== want.found_handle)
                        report_mismatch("found_handle", m_data.found_handle,
                                        want.found_handle);
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.evicted !== want.evicted)
                        report_mismatch("evicted", m_data.evicted, want.evicted);
                    if (m_data.fill_count !== want.fill_count)
                        report_mismatch("fill_count", m_data.fill_count,
                                        want.fill_count);
                end
            end
            if (s_valid && s_ready) result_q.push_back(store_apply(s_data));
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb_skipped_key_bounded_store_unit.sv =====
//------------------------------------------------------------------------------
// tb_skipped_key_bounded_store_unit
// Drives add, find, delete and no-op beats into the skipped key store with
// random idling on both sides and a checker beside the block, then gives a verdict.
//------------------------------------------------------------------------------
`default_nettype none
module tb_skipped_key_bounded_store_unit
    import sks_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth     = DefMaxEntries;
    localparam int CycleMax  = 1_000_000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sks_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sks_out_t m_data;
    int       err_count;
    int       pending;
    int       cycles = 0;
    int       send_idle = 16;
    int       recv_idle = 69;
    bit       hold_recv = 1'b0;

    // Recently added keys, so that finds and deletes hit.
    logic [31:0] epoch_pool[$];
    logic [31:0] index_pool[$];
    logic [63:0] handle_pool[$];

    always #6 aclk = ~aclk;

    skipped_key_bounded_store_unit #(.MaxEntries(Depth)) i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    sks_checker #(.MaxEntries(Depth)) i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready,
        .m_data, .err_count, .pending
    );

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleMax) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge aclk) begin
        if (hold_recv) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Offers one beat and waits for it to be taken. Valid stays high after
    // the beat is taken; the next call may lower it while idling, and drain() lowers it.
    task automatic send_beat(input op_t op, input logic [31:0] ep,
                             input logic [31:0] mi, input logic [63:0] hd);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{op, ep, mi, hd};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (op == OP_ADD) begin
            epoch_pool.push_back(ep);
            index_pool.push_back(mi);
            handle_pool.push_back(hd);
            if (handle_pool.size() > 40) begin
                void'(epoch_pool.pop_front());
                void'(index_pool.pop_front());
                void'(handle_pool.pop_front());
            end
        end
    endtask

    // Random beat: mostly adds and hitting finds or deletes, some misses.
    task automatic send_random();
        int          k;
        int          pick;
        logic [31:0] ep;
        logic [31:0] mi;
        logic [63:0] hd;
        ep   = $urandom;
        mi   = $urandom;
        hd   = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (handle_pool.size() > 0 && $urandom_range(3) != 0) begin
            k  = $urandom_range(handle_pool.size() - 1);
            ep = epoch_pool[k];
            mi = index_pool[k];
            hd = handle_pool[k];
            // Small value sets give duplicates now and then.
            if ($urandom_range(7) == 0) hd = {62'd0, 2'($urandom)};
        end
        if (pick < 40) send_beat(OP_ADD, $urandom, $urandom, hd);
        else if (pick < 68) send_beat(OP_FIND, ep, mi, hd);
        else if (pick < 96) send_beat(OP_DEL, ep, mi, hd);
        else send_beat(OP_NONE, ep, mi, hd);
    endtask

    // Stops offering and waits until every expected result has come.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty store, extremes, duplicates, overflow.
        send_beat(OP_FIND, '0, '0, '0);
        send_beat(OP_DEL, '0, '0, '0);
        send_beat(OP_NONE, '1, '1, '1);
        send_beat(OP_ADD, '1, '1, '1);
        send_beat(OP_ADD, '0, '0, '0);
        send_beat(OP_ADD, 32'h5, 32'h7, 64'h1);
        send_beat(OP_ADD, 32'h5, 32'h7, 64'h1);
        send_beat(OP_FIND, 32'h5, 32'h7, '0);
        send_beat(OP_FIND, '1, '1, '0);
        send_beat(OP_FIND, 32'h5, 32'h8, '0);
        send_beat(OP_DEL, '0, '0, 64'h1);
        send_beat(OP_DEL, '0, '0, 64'h2);
        send_beat(OP_DEL, '0, '0, '1);
        send_beat(OP_FIND, '1, '1, '0);
        send_beat(OP_NONE, '0, '0, '0);
        drain();

        // Fill past capacity while the receiver holds off.
        hold_recv = 1'b1;
        fork
            begin
                for (int i = 0; i < Depth + 4; i++)
                    send_beat(OP_ADD, i, i, 64'h100 + i);
            end
            begin
                repeat (200) @(negedge aclk);
                hold_recv = 1'b0;
            end
        join
        drain();
        send_beat(OP_FIND, 32'd4, 32'd4, '0);
        send_beat(OP_FIND, 32'd3, 32'd3, '0);
        send_beat(OP_DEL, '0, '0, 64'h104);
        send_beat(OP_DEL, '0, '0, 64'h100 + Depth + 3);

        // Random phases with changing idle rates.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 16 : (ph == 1) ? 69 : 0;
            recv_idle = (ph == 0) ? 69 : (ph == 1) ? 16 : 0;
            for (int n = 0; n < 130; n++) send_random();
            drain();
        end

        repeat (50) @(negedge aclk);
        if (err_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
